FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication, checked outside reset
`define OTTA_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: implication check failed");

// next-cycle implication, checked outside reset
`define OTTA_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: next-cycle check failed");

// implication that also holds across reset
`define OTTA_ASSERT_RAW(lbl, clk, pre, post) \
   lbl: assert property (@(posedge clk) (pre) |-> (post)) \
      else $error("%m: reset-time check failed");

`endif

FILE: src/otta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package otta_pkg;

   localparam int unsigned CNT_W     = 16;
   localparam int unsigned DUR_W     = 32;
   localparam int unsigned TIME_W    = 64;
   // ticks passed between two samples, up to two counter periods
   localparam int unsigned VAL_W     = 17;
   localparam int unsigned MULT_W    = 11;
   localparam int unsigned PROD_W    = 28;
   // shift for exact reciprocal division of a PROD_W-bit value by a divisor < 2**DIV_L
   localparam int unsigned DIV_L     = 11;
   localparam int unsigned DIV_SHIFT = PROD_W + DIV_L;
   localparam int unsigned RECIP_W   = 30;
   localparam int unsigned QUO_W     = PROD_W + RECIP_W - DIV_SHIFT;

   localparam logic [MULT_W-1:0] TICKS_PER_MSEC = 11'd1193;
   localparam logic [MULT_W-1:0] US_PER_MSEC    = 11'd1000;

   localparam int unsigned        COUNTER_MAX = 65535;
   localparam logic [VAL_W-1:0]   COUNTER_TOP = VAL_W'(COUNTER_MAX + 1);
   localparam logic [CNT_W-1:0]   LOAD_LIMIT  = CNT_W'(16'hffff);
   localparam logic [CNT_W-1:0]   MIN_TIMEOUT_US = CNT_W'(1000 * 1000 / (4 * 1000));
   localparam logic [CNT_W-1:0]   MAX_TIMEOUT_RESET = 16'd54932;

   // ceil(2**DIV_SHIFT / divisor)
   localparam logic [RECIP_W-1:0] RECIP_BY_US_PER_MSEC = RECIP_W'(
      ((64'd1 << DIV_SHIFT) + 64'(US_PER_MSEC) - 64'd1) / 64'(US_PER_MSEC));
   localparam logic [RECIP_W-1:0] RECIP_BY_TICKS_PER_MSEC = RECIP_W'(
      ((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_MSEC) - 64'd1) / 64'(TICKS_PER_MSEC));

   typedef enum logic [0:0] {
      CMD_SCHEDULE = 1'b0,
      CMD_UPDATE   = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CONV_TO_TICKS = 1'b0,
      CONV_TO_US    = 1'b1
   } conv_mode_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [CNT_W-1:0] sample;
      logic             wrap;
      logic [CNT_W-1:0] load;
   } tag_type;

endpackage

`default_nettype wire

FILE: src/otta_convert.sv
`timescale 1ns / 1ps
`default_nettype none

// two-stage constant scale: value * mul, then exact divide by reciprocal
module otta_convert (
   input  logic                         clock,
   input  logic                         reset,
   input  otta_pkg::conv_mode_type      mode,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [otta_pkg::VAL_W-1:0]   in_value,
   input  otta_pkg::tag_type            in_tag,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [otta_pkg::QUO_W-1:0]   out_quotient,
   output otta_pkg::tag_type            out_tag
);
   import otta_pkg::*;

   logic                        prod_valid_ff, prod_valid_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   tag_type                     prod_tag_ff;
   logic                        quo_valid_ff, quo_valid_in;
   logic [QUO_W-1:0]            quo_ff, quo_in;
   tag_type                     quo_tag_ff;
   logic [MULT_W-1:0]           scale;
   logic [RECIP_W-1:0]          recip;
   logic [PROD_W-1:0]           value_ext, scale_ext;
   logic [PROD_W+RECIP_W-1:0]   prod_wide, recip_wide, wide;
   logic                        prod_ready, quo_ready, prod_load, quo_load;

   always_comb begin
      unique case (mode)
         CONV_TO_TICKS: begin
            scale = TICKS_PER_MSEC;
            recip = RECIP_BY_US_PER_MSEC;
         end
         CONV_TO_US: begin
            scale = US_PER_MSEC;
            recip = RECIP_BY_TICKS_PER_MSEC;
         end
         default: begin
            scale = US_PER_MSEC;
            recip = RECIP_BY_TICKS_PER_MSEC;
         end
      endcase
   end

   assign value_ext  = PROD_W'(in_value);
   assign scale_ext  = PROD_W'(scale);
   assign prod_in    = value_ext * scale_ext;
   assign prod_wide  = (PROD_W + RECIP_W)'(prod_ff);
   assign recip_wide = (PROD_W + RECIP_W)'(recip);
   assign wide       = prod_wide * recip_wide;
   assign quo_in     = wide[DIV_SHIFT +: QUO_W];

   // handshake between the two stages
   assign quo_ready     = !quo_valid_ff || out_ready;
   assign prod_ready    = !prod_valid_ff || quo_ready;
   assign prod_load     = in_valid && prod_ready;
   assign quo_load      = prod_valid_ff && quo_ready;
   assign prod_valid_in = prod_load || (prod_valid_ff && !quo_ready);
   assign quo_valid_in  = quo_load || (quo_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         quo_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         quo_valid_ff  <= quo_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff     <= prod_in;
         prod_tag_ff <= in_tag;
      end
      if (quo_load) begin
         quo_ff     <= quo_in;
         quo_tag_ff <= prod_tag_ff;
      end
   end

   assign in_ready     = prod_ready;
   assign out_valid    = quo_valid_ff;
   assign out_quotient = quo_ff;
   assign out_tag      = quo_tag_ff;

endmodule

`default_nettype wire

FILE: src/otta_track.sv
`timescale 1ns / 1ps
`default_nettype none

// counter reference tracking: reload on schedule, ticks passed on update
module otta_track (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [otta_pkg::QUO_W-1:0]   in_ticks,
   input  otta_pkg::tag_type            in_tag,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [otta_pkg::VAL_W-1:0]   out_passed,
   output otta_pkg::tag_type            out_tag
);
   import otta_pkg::*;

   logic [CNT_W-1:0] ref_ff, ref_in;
   logic             wrap_handled_ff, wrap_handled_in;
   logic             valid_ff, valid_in;
   logic [VAL_W-1:0] passed_ff, passed_in;
   tag_type          tag_ff, tag_in;
   logic [CNT_W-1:0] ticks_sat;
   logic [VAL_W-1:0] ref_ext, sample_ext, to_top;
   logic             load;

   assign ticks_sat  = (in_ticks > QUO_W'(LOAD_LIMIT)) ? LOAD_LIMIT : in_ticks[CNT_W-1:0];
   assign ref_ext    = VAL_W'(ref_ff);
   assign sample_ext = VAL_W'(in_tag.sample);
   assign to_top     = COUNTER_TOP - sample_ext;

   always_comb begin
      ref_in          = ref_ff;
      wrap_handled_in = wrap_handled_ff;
      passed_in       = '0;
      tag_in          = in_tag;
      if (in_tag.cmd == CMD_SCHEDULE) begin
         ref_in          = ticks_sat;
         wrap_handled_in = 1'b0;
         tag_in.load     = ticks_sat;
      end else begin
         tag_in.load = '0;
         ref_in      = in_tag.sample;
         if (in_tag.wrap && !wrap_handled_ff) begin
            // first sight of a wrap: rest of the old period plus the new one
            passed_in       = (in_tag.sample != '0) ? ref_ext + to_top : ref_ext;
            wrap_handled_in = 1'b1;
         end else if (ref_ff == '0) begin
            passed_in = to_top;
         end else if (sample_ext <= ref_ext) begin
            passed_in = ref_ext - sample_ext;
         end else begin
            // count went up again without a flagged wrap
            passed_in = ref_ext + to_top;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         ref_ff          <= '0;
         wrap_handled_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            ref_ff          <= ref_in;
            wrap_handled_ff <= wrap_handled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         passed_ff <= passed_in;
         tag_ff    <= tag_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_passed = passed_ff;
   assign out_tag    = tag_ff;

endmodule

`default_nettype wire

FILE: src/otta_accum.sv
`timescale 1ns / 1ps
`default_nettype none

// running time total and the result register
module otta_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [otta_pkg::QUO_W-1:0]   in_quotient,
   input  otta_pkg::tag_type            in_tag,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [otta_pkg::TIME_W-1:0]  rsp_elapsed_time_us,
   output logic [otta_pkg::CNT_W-1:0]   rsp_counter_load,
   output logic                         rsp_load_valid
);
   import otta_pkg::*;

   logic              valid_ff, valid_in;
   logic [TIME_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0] elapsed_ff;
   logic [CNT_W-1:0]  counter_load_ff;
   logic              load_valid_ff;
   logic              load;

   assign total_in = (in_tag.cmd == CMD_UPDATE) ? total_ff + TIME_W'(in_quotient) : total_ff;

   assign in_ready = !valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         elapsed_ff      <= total_in;
         counter_load_ff <= in_tag.load;
         load_valid_ff   <= (in_tag.cmd == CMD_SCHEDULE);
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_elapsed_time_us = elapsed_ff;
   assign rsp_counter_load    = counter_load_ff;
   assign rsp_load_valid      = load_valid_ff;

endmodule

`default_nettype wire

FILE: src/oneshot_timer_time_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | transfer when          | carries
// req_     | in        | req_valid & req_ready  | command, duration, counter sample, wrap bit
// rsp_     | out       | rsp_valid & rsp_ready  | elapsed time, counter load value, load flag
// csr_     | in        | csr_valid & csr_ready  | max_timeout_us (csr_ready is always high)
//
// one item per cycle unless rsp_ready stalls the pipeline; each stage holds a register
// the per-item loop is the reference count / wrap mark register in the tracker,
// which each item reads and updates as it loads, so back-to-back items see each other's state
// synchronous reset clears all valid flags, the reference, the wrap mark and the total,
// and loads max_timeout_us with 54932
// every stage holds its item while the next is full; empty stages still take items,
// so the input keeps moving while a finished result waits on rsp_ready
module oneshot_timer_time_accumulator (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [otta_pkg::DUR_W-1:0]   req_duration_us,
   input  logic [otta_pkg::CNT_W-1:0]   req_counter_sample,
   input  logic                         req_wrap_seen,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [otta_pkg::TIME_W-1:0]  rsp_elapsed_time_us,
   output logic [otta_pkg::CNT_W-1:0]   rsp_counter_load,
   output logic                         rsp_load_valid,
   // configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [otta_pkg::CNT_W-1:0]   csr_max_timeout_us
);
   import otta_pkg::*;

   // input register
   logic             req_valid_ff, req_valid_in;
   cmd_type          cmd_ff;
   logic [DUR_W-1:0] duration_ff;
   logic [CNT_W-1:0] sample_ff;
   logic             wrap_ff;
   logic             req_load;

   // configuration
   logic [CNT_W-1:0] max_timeout_ff;

   // timeout clamp
   logic [DUR_W-1:0] dur_floor;
   logic [CNT_W-1:0] dur_clamped;
   tag_type          front_tag;

   // stage links
   logic             tick_in_ready, tick_valid, track_in_ready;
   logic [QUO_W-1:0] tick_quotient;
   tag_type          tick_tag;
   logic             track_valid, us_in_ready;
   logic [VAL_W-1:0] track_passed;
   tag_type          track_tag;
   logic             us_valid, accum_in_ready;
   logic [QUO_W-1:0] us_quotient;
   tag_type          us_tag;

   // max_timeout_us register, written whenever the csr channel offers data
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_timeout_ff <= MAX_TIMEOUT_RESET;
      end else if (csr_valid) begin
         max_timeout_ff <= csr_max_timeout_us;
      end
   end

   // request register
   assign req_ready    = !req_valid_ff || tick_in_ready;
   assign req_load     = req_valid && req_ready;
   assign req_valid_in = req_load || (req_valid_ff && !tick_in_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         cmd_ff      <= cmd_type'(req_command);
         duration_ff <= req_duration_us;
         sample_ff   <= req_counter_sample;
         wrap_ff     <= req_wrap_seen;
      end
   end

   // floor first, then the configured maximum, so a maximum under the floor wins
   assign dur_floor   = (duration_ff < DUR_W'(MIN_TIMEOUT_US)) ? DUR_W'(MIN_TIMEOUT_US)
                                                                : duration_ff;
   assign dur_clamped = (dur_floor > DUR_W'(max_timeout_ff)) ? max_timeout_ff
                                                             : dur_floor[CNT_W-1:0];

   always_comb begin
      front_tag        = '0;
      front_tag.cmd    = cmd_ff;
      front_tag.sample = sample_ff;
      front_tag.wrap   = wrap_ff;
   end

   // microseconds to counter ticks (only schedule items use the result)
   otta_convert u_tick_convert (
      .clock        (clock),
      .reset        (reset),
      .mode         (CONV_TO_TICKS),
      .in_valid     (req_valid_ff),
      .in_ready     (tick_in_ready),
      .in_value     (VAL_W'(dur_clamped)),
      .in_tag       (front_tag),
      .out_valid    (tick_valid),
      .out_ready    (track_in_ready),
      .out_quotient (tick_quotient),
      .out_tag      (tick_tag)
   );

   // reference count and wrap mark
   otta_track u_track (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (tick_valid),
      .in_ready   (track_in_ready),
      .in_ticks   (tick_quotient),
      .in_tag     (tick_tag),
      .out_valid  (track_valid),
      .out_ready  (us_in_ready),
      .out_passed (track_passed),
      .out_tag    (track_tag)
   );

   // passed ticks to microseconds
   otta_convert u_us_convert (
      .clock        (clock),
      .reset        (reset),
      .mode         (CONV_TO_US),
      .in_valid     (track_valid),
      .in_ready     (us_in_ready),
      .in_value     (track_passed),
      .in_tag       (track_tag),
      .out_valid    (us_valid),
      .out_ready    (accum_in_ready),
      .out_quotient (us_quotient),
      .out_tag      (us_tag)
   );

   // running total and result register
   otta_accum u_accum (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (us_valid),
      .in_ready            (accum_in_ready),
      .in_quotient         (us_quotient),
      .in_tag              (us_tag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_elapsed_time_us (rsp_elapsed_time_us),
      .rsp_counter_load    (rsp_counter_load),
      .rsp_load_valid      (rsp_load_valid)
   );

endmodule

`default_nettype wire

FILE: src/otta_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module otta_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_command,
   input logic [otta_pkg::DUR_W-1:0]   req_duration_us,
   input logic [otta_pkg::CNT_W-1:0]   req_counter_sample,
   input logic                         req_wrap_seen,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [otta_pkg::TIME_W-1:0]  rsp_elapsed_time_us,
   input logic [otta_pkg::CNT_W-1:0]   rsp_counter_load,
   input logic                         rsp_load_valid,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [otta_pkg::CNT_W-1:0]   csr_max_timeout_us
);

   logic                                        rsp_stall;
   logic [otta_pkg::TIME_W+otta_pkg::CNT_W:0]   rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_elapsed_time_us, rsp_counter_load, rsp_load_valid};

   // a stalled result holds
   `OTTA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // reset empties the result register
   `OTTA_ASSERT_RAW(a_reset_empty, clock, $past(reset) && !reset, !rsp_valid)

   // a free output slot lets the whole pipeline take a new request
   `OTTA_ASSERT_IMP(a_ready_flow, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // update results never carry a counter load value
   `OTTA_ASSERT_IMP(a_update_no_load, clock, reset, rsp_valid && !rsp_load_valid, rsp_counter_load == '0)

endmodule

bind oneshot_timer_time_accumulator otta_checker u_otta_checker (.*);

`default_nettype wire
